[rtl/vit_pkg.sv]
package vit_pkg;

	// fixed field widths of the request and response transactions
	localparam int KEY_W       = 48;
	localparam int ID_W        = 6;
	localparam int STATUS_W    = 2;
	// entry_id is 6 bits, so at most this many entries are addressable
	localparam int MAX_ENTRIES = 64;

	localparam logic OP_INTERN = 1'b0;
	localparam logic OP_FETCH  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture request payload, restart scan
		logic step;        // issue next scan read
		logic take_hit;    // result = matched entry
		logic take_miss;   // append key or flag full
		logic fetch_rd;    // read entry at requested index
		logic take_fetch;  // result = fetched entry
		logic publish;     // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;         // entry in read stage equals key
		logic drained;     // all filled entries issued and compared
		logic out_free;    // output register can take a result
	} stat_t;

endpackage

[rtl/vit_ifs.sv]
interface vit_req_if;
	import vit_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [KEY_W-1:0] key;
	logic [ID_W-1:0]  index;

	modport source (output valid, output op, output key, output index, input ready);
	modport sink (input valid, input op, input key, input index, output ready);
endinterface

interface vit_rsp_if;
	import vit_pkg::*;

	logic                valid;
	logic                ready;
	logic [ID_W-1:0]     entry_id;
	logic [KEY_W-1:0]    entry_value;
	logic                was_added;
	logic [STATUS_W-1:0] status;

	modport source (
		output valid, output entry_id, output entry_value, output was_added,
		output status, input ready
	);
	modport sink (
		input valid, input entry_id, input entry_value, input was_added,
		input status, output ready
	);
endinterface

[rtl/vit_datapath.sv]
module vit_datapath #(
	parameter int VECTOR_BYTES = 6,
	parameter int TABLE_DEPTH  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vit_pkg::cmd_t                    cmd,
	output vit_pkg::stat_t                   stat,
	input  logic [vit_pkg::KEY_W-1:0]        req_key,
	input  logic [vit_pkg::ID_W-1:0]         req_index,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [vit_pkg::ID_W-1:0]         rsp_entry_id,
	output logic [vit_pkg::KEY_W-1:0]        rsp_entry_value,
	output logic                             rsp_was_added,
	output logic [vit_pkg::STATUS_W-1:0]     rsp_status
);
	import vit_pkg::*;

	localparam int CAP      = (TABLE_DEPTH < MAX_ENTRIES) ? TABLE_DEPTH : MAX_ENTRIES;
	localparam int AW       = $clog2(CAP);
	localparam int CW       = $clog2(CAP + 1);
	localparam int CMP_W    = ID_W + 1;
	localparam int KEY_BITS = (8 * VECTOR_BYTES < KEY_W) ? 8 * VECTOR_BYTES : KEY_W;

	logic [KEY_BITS-1:0] mem [CAP];

	logic [KEY_BITS-1:0] key_q;
	logic [ID_W-1:0]     idx_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       ptr_q;
	logic                rvalid_s1;
	logic [AW-1:0]       raddr_s1;
	logic [KEY_BITS-1:0] rdata_s1;

	logic [ID_W-1:0]     res_id_q;
	logic [KEY_BITS-1:0] res_val_q;
	logic                res_added_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;

	logic          issue_ok;
	logic          full;
	logic          fetch_ok;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign issue_ok = ptr_q < fill_q;
	assign full     = fill_q == CW'(CAP);
	assign fetch_ok = CMP_W'(idx_q) < CMP_W'(fill_q);
	assign rd_en    = (cmd.step && issue_ok) || cmd.fetch_rd;
	assign rd_addr  = cmd.fetch_rd ? idx_q[AW-1:0] : ptr_q[AW-1:0];

	assign stat.hit      = rvalid_s1 && (rdata_s1 == key_q);
	assign stat.drained  = !rvalid_s1 && !issue_ok;
	assign stat.out_free = !out_valid_q || rsp_ready;

	// table storage: one write port (append), one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take_miss && !full) begin
			mem[fill_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			ptr_q       <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q     <= '0;
				rvalid_s1 <= 1'b0;
			end else if (cmd.step) begin
				rvalid_s1 <= issue_ok;
				if (issue_ok) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end else begin
				rvalid_s1 <= 1'b0;
			end
			if (cmd.take_miss && !full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= req_key[KEY_BITS-1:0];
			idx_q <= req_index;
		end
		if (cmd.step) begin
			raddr_s1 <= ptr_q[AW-1:0];
		end
		if (cmd.take_hit) begin
			res_id_q     <= ID_W'(raddr_s1);
			res_val_q    <= rdata_s1;
			res_added_q  <= 1'b0;
			res_status_q <= STATUS_OK;
		end else if (cmd.take_miss) begin
			if (full) begin
				res_id_q     <= '0;
				res_val_q    <= '0;
				res_added_q  <= 1'b0;
				res_status_q <= STATUS_FULL;
			end else begin
				res_id_q     <= ID_W'(fill_q);
				res_val_q    <= key_q;
				res_added_q  <= 1'b1;
				res_status_q <= STATUS_OK;
			end
		end else if (cmd.take_fetch) begin
			res_id_q     <= idx_q;
			res_val_q    <= fetch_ok ? rdata_s1 : '0;
			res_added_q  <= 1'b0;
			res_status_q <= fetch_ok ? STATUS_OK : STATUS_BAD_INDEX;
		end
		if (cmd.publish) begin
			rsp_entry_id    <= res_id_q;
			rsp_entry_value <= KEY_W'(res_val_q);
			rsp_was_added   <= res_added_q;
			rsp_status      <= res_status_q;
		end
	end

	assign rsp_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAP))
		else $error("fill count beyond table capacity");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || rsp_ready))
		else $error("result published over an untaken response");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_miss && !full) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("append did not advance fill count");
`endif

endmodule

[rtl/vit_ctrl.sv]
module vit_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_op,
	output logic            req_ready,
	output vit_pkg::cmd_t   cmd,
	input  vit_pkg::stat_t  stat
);
	import vit_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_FETCH = 5'b00100,
		S_FWAIT = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_ready = state_q == S_IDLE;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (req_op == OP_FETCH) ? S_FETCH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = S_RESP;
				end else if (stat.drained) begin
					cmd.take_miss = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FETCH: begin
				cmd.fetch_rd = 1'b1;
				state_d      = S_FWAIT;
			end
			S_FWAIT: begin
				cmd.take_fetch = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_intern_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_op == OP_INTERN) |=> state_q == S_SCAN)
		else $error("intern transaction did not start a scan");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.take_hit, cmd.take_miss, cmd.take_fetch}) <= 1)
		else $error("more than one result source selected");
`endif

endmodule

[rtl/vector_intern_table_core.sv]
// Channel  Dir  Transaction payload
// req      in   op, key[47:0], index[5:0]
// rsp      out  entry_id[5:0], entry_value[47:0], was_added, status[1:0]
//
// One request at a time. Intern miss: the response follows a scan of every filled entry;
// a hit at entry i ends the scan there. The scan compares one entry per cycle through
// the single registered read port. Fetch reads the requested index without a scan.
// Reset clears fill count and control; table words stay undefined until appended.
// A waiting response sits in the output register; req is taken again the cycle after
// the response is loaded there, and only that load stalls on rsp.ready.
module vector_intern_table_core #(
	parameter int VECTOR_BYTES = 6,
	parameter int TABLE_DEPTH  = 64
) (
	input logic      clk,
	input logic      arst_n,
	vit_req_if.sink  req,
	vit_rsp_if.source rsp
);
	import vit_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// controller: sequences accept, scan/fetch, result selection, hand-off
	vit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: table memory, scan pipeline, fill count, result/output regs
	vit_datapath #(
		.VECTOR_BYTES (VECTOR_BYTES),
		.TABLE_DEPTH  (TABLE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_key         (req.key),
		.req_index       (req.index),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_entry_id    (rsp.entry_id),
		.rsp_entry_value (rsp.entry_value),
		.rsp_was_added   (rsp.was_added),
		.rsp_status      (rsp.status)
	);

endmodule

[dv/tb_vector_intern_table_core.sv]
`timescale 1ns / 1ps

module tb_vector_intern_table_core;
	import vit_pkg::*;

	// block configuration under test
	localparam int VEC_BYTES = 6;
	localparam int TBL_DEPTH = 64;

	// longest correct quiet stretch is a full-table scan plus a receiver
	// stall; this is several times that
	localparam int STALL_LIMIT = 2000;
	// drain time after the last response: one full scan and some margin
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 2000;

	// one response transaction
	typedef struct {
		logic [ID_W-1:0]     id;
		logic [KEY_W-1:0]    value;
		logic                added;
		logic [STATUS_W-1:0] status;
	} intern_rsp_t;

	// Scoreboard: keeps its own copy of the table, predicts each response as the
	// request is accepted, and checks responses in order.
	class intern_scoreboard;
		logic [KEY_W-1:0] stored_keys[MAX_ENTRIES];
		int unsigned      fill;
		int unsigned      capacity;
		logic [KEY_W-1:0] key_mask;
		intern_rsp_t      expected_q[$];
		int               errors;

		function new();
			fill     = 0;
			errors   = 0;
			capacity = (TBL_DEPTH < MAX_ENTRIES) ? TBL_DEPTH : MAX_ENTRIES;
			if (VEC_BYTES >= 6)
				key_mask = '1;
			else
				key_mask = (48'h1 << (8 * VEC_BYTES)) - 48'h1;
		endfunction

		function void note_request(logic op, logic [KEY_W-1:0] key, logic [ID_W-1:0] idx);
			intern_rsp_t      exp;
			logic [KEY_W-1:0] k;
			bit               found;
			exp.id     = '0;
			exp.value  = '0;
			exp.added  = 1'b0;
			exp.status = STATUS_OK;
			k          = key & key_mask;
			found      = 0;
			if (op == OP_INTERN) begin
				// first match in index order wins
				for (int unsigned i = 0; i < fill && !found; i++) begin
					if (stored_keys[i] == k) begin
						exp.id    = ID_W'(i);
						exp.value = stored_keys[i];
						found     = 1;
					end
				end
				if (!found) begin
					if (fill < capacity) begin
						stored_keys[fill] = k;
						exp.id    = ID_W'(fill);
						exp.value = k;
						exp.added = 1'b1;
						fill++;
					end else begin
						exp.status = STATUS_FULL;
					end
				end
			end else begin
				exp.id = idx;
				if (idx < fill)
					exp.value = stored_keys[idx];
				else
					exp.status = STATUS_BAD_INDEX;
			end
			expected_q = {expected_q, exp};
		endfunction

		function void check_response(intern_rsp_t got);
			intern_rsp_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response id=%0d value=%h added=%b status=%0d",
					$time, got.id, got.value, got.added, got.status);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (got.id !== exp.id) begin
					$display("%0t: entry_id mismatch exp=%0d act=%0d", $time, exp.id, got.id);
					errors++;
				end
				if (got.value !== exp.value) begin
					$display("%0t: entry_value mismatch exp=%h act=%h",
						$time, exp.value, got.value);
					errors++;
				end
				if (got.added !== exp.added) begin
					$display("%0t: was_added mismatch exp=%b act=%b",
						$time, exp.added, got.added);
					errors++;
				end
				if (got.status !== exp.status) begin
					$display("%0t: status mismatch exp=%0d act=%0d",
						$time, exp.status, got.status);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	vit_req_if req_if ();
	vit_rsp_if rsp_if ();

	vector_intern_table_core #(
		.VECTOR_BYTES(VEC_BYTES),
		.TABLE_DEPTH (TBL_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	intern_scoreboard sb;

	// idle percentages for the sender and receiver, changed per phase
	int send_idle;
	int rsp_idle;
	int stall_cycles;

	// keys already offered to the block, reused to provoke hits
	logic [KEY_W-1:0] key_pool[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender: optional idle cycles, then hold the transaction until accepted.
	// valid is left high on accept so back-to-back transactions don't glitch it.
	task automatic send_req(logic op, logic [KEY_W-1:0] key, logic [ID_W-1:0] idx);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.key   <= key;
		req_if.index <= idx;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note_request(op, key, idx);
	endtask

	task automatic send_intern(logic [KEY_W-1:0] key);
		key_pool = {key_pool, key};
		send_req(OP_INTERN, key, ID_W'($urandom_range(63)));
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Receiver: sample the handshake seen at this edge, then pick next ready.
	always @(posedge clk) begin
		intern_rsp_t got;
		if (rsp_if.valid && rsp_if.ready) begin
			got.id     = rsp_if.entry_id;
			got.value  = rsp_if.entry_value;
			got.added  = rsp_if.was_added;
			got.status = rsp_if.status;
			sb.check_response(got);
		end
		rsp_if.ready <= ($urandom_range(99) >= rsp_idle);
	end

	// Watchdog: any cycle with no transaction on either side counts as a stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int               r;
		logic [KEY_W-1:0] k;
		sb           = new();
		send_idle    = 15;
		rsp_idle     = 55;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.op    = OP_INTERN;
		req_if.key   = '0;
		req_if.index = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fetch on an empty table is out of range at both ends
		send_req(OP_FETCH, '0, 6'd0);
		send_req(OP_FETCH, '1, 6'd63);
		// extremes of the key, repeats that must hit, then alternating-bit keys
		send_intern(48'h0);
		send_intern(48'hFFFF_FFFF_FFFF);
		send_intern(48'h0);
		send_intern(48'hFFFF_FFFF_FFFF);
		send_intern(48'h5555_5555_5555);
		send_intern(48'hAAAA_AAAA_AAAA);
		// keys that differ from an entry only in the top or bottom bit
		send_intern(48'h8000_0000_0000);
		send_intern(48'h0000_0000_0001);
		send_intern(48'h7FFF_FFFF_FFFF);
		send_intern(48'hAAAA_AAAA_AAAA);
		// fetch inside, at and beyond the fill count
		send_req(OP_FETCH, '0, 6'd0);
		send_req(OP_FETCH, '0, 6'd1);
		send_req(OP_FETCH, '1, 6'd6);
		send_req(OP_FETCH, '0, 6'd7);
		send_req(OP_FETCH, '0, 6'd8);
		send_req(OP_FETCH, '0, 6'd63);
		send_intern(48'h8000_0000_0000);

		// random: mix of fetches, hits on known keys and fresh keys; fresh keys
		// are rare enough that the partly filled table sees a long run before
		// the full-table behavior takes over
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle = 55;
				rsp_idle  = 15;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				rsp_idle  = 0;
			end
			r = $urandom_range(99);
			if (r < 25) begin
				send_req(OP_FETCH, random_key(), ID_W'($urandom_range(63)));
			end else if (r < 80) begin
				k = key_pool[$urandom_range(key_pool.size() - 1)];
				send_req(OP_INTERN, k, ID_W'($urandom_range(63)));
			end else if (r < 90) begin
				// near miss: one bit away from a known key
				k = key_pool[$urandom_range(key_pool.size() - 1)];
				send_intern(k ^ (48'h1 << $urandom_range(KEY_W - 1)));
			end else begin
				send_intern(random_key());
			end
		end
		req_if.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// catch any stray extra response
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
